/* src/vbs_pkg.sv */
package vbs_pkg;

  // One body as it enters the block.
  typedef struct packed {
    logic               is_static;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [23:0] damping;
    logic        [23:0] friction;
  } vbs_in_t;

  // One stepped body as it leaves the block.
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_prev_x;
    logic signed [31:0] new_prev_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } vbs_out_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_SQUARED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DT     = 2'd3;

  localparam logic [31:0] INV_DT_RESET = 32'd65536;

  // Clamp a wide signed value into the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* src/vbs_axis.sv */
module vbs_axis import vbs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] grav_i,
  input  logic signed [31:0] pos_i,
  input  logic signed [31:0] prev_i,
  input  logic signed [31:0] vel_i,
  input  logic        [24:0] coef_i,
  input  logic        [31:0] dt_sq_i,
  input  logic        [31:0] inv_dt_i,
  output logic signed [31:0] new_pos_o,
  output logic signed [31:0] new_vel_o
);

  localparam logic [56:0] HALF_S2 = 57'(1) << (FRAC_BITS - 1);
  localparam logic [65:0] HALF_S6 = 66'(1) << (FRAC_BITS - 1);

  // stage 1: |v| * (damping + friction)
  logic        [31:0] vel_mag;
  logic               s1_neg_q;
  logic        [56:0] s1_prod_q;
  logic signed [31:0] s1_pos_q, s1_prev_q;

  assign vel_mag = vel_i[31] ? 32'(~$unsigned(vel_i) + 32'd1) : $unsigned(vel_i);

  always_ff @(posedge clk_i) begin
    s1_neg_q  <= vel_i[31];
    s1_prod_q <= 57'(vel_mag) * 57'(coef_i);
    s1_pos_q  <= pos_i;
    s1_prev_q <= prev_i;
  end

  // stage 2: round, subtract from gravity, clamp
  logic        [56:0] s2_rnd;
  logic signed [58:0] s2_acc_raw;
  logic signed [58:0] s2_grav_ext, s2_drag_ext;
  logic signed [31:0] s2_acc_q, s2_pos_q, s2_prev_q;

  always_comb begin
    s2_rnd      = (s1_prod_q + HALF_S2) >> FRAC_BITS;
    s2_grav_ext = {{27{grav_i[31]}}, grav_i};
    s2_drag_ext = {2'b00, s2_rnd};
    s2_acc_raw  = s1_neg_q ? s2_grav_ext + s2_drag_ext : s2_grav_ext - s2_drag_ext;
  end

  always_ff @(posedge clk_i) begin
    s2_acc_q  <= sat32({{13{s2_acc_raw[58]}}, s2_acc_raw});
    s2_pos_q  <= s1_pos_q;
    s2_prev_q <= s1_prev_q;
  end

  // stage 3: |a| * dt^2
  logic        [31:0] acc_mag;
  logic               s3_neg_q;
  logic        [63:0] s3_prod_q;
  logic signed [31:0] s3_pos_q, s3_prev_q;

  assign acc_mag = s2_acc_q[31] ? 32'(~$unsigned(s2_acc_q) + 32'd1) : $unsigned(s2_acc_q);

  always_ff @(posedge clk_i) begin
    s3_neg_q  <= s2_acc_q[31];
    s3_prod_q <= 64'(acc_mag) * 64'(dt_sq_i);
    s3_pos_q  <= s2_pos_q;
    s3_prev_q <= s2_prev_q;
  end

  // stage 4: next = 2p - prev + term, clamp, form next - p
  logic        [64:0] s4_sum;
  logic signed [35:0] s4_term, s4_term_mag, s4_pos2, s4_prev_ext, s4_next_raw;
  logic signed [31:0] s4_next;
  logic signed [31:0] s4_next_q;
  logic signed [32:0] s4_diff_q;

  always_comb begin
    s4_sum      = {1'b0, s3_prod_q} + 65'h0_8000_0000;
    s4_term_mag = {3'b000, s4_sum[64:32]};
    s4_term     = s3_neg_q ? -s4_term_mag : s4_term_mag;
    s4_pos2     = {{3{s3_pos_q[31]}}, s3_pos_q, 1'b0};
    s4_prev_ext = {{4{s3_prev_q[31]}}, s3_prev_q};
    s4_next_raw = s4_pos2 - s4_prev_ext + s4_term;
    s4_next     = sat32({{36{s4_next_raw[35]}}, s4_next_raw});
  end

  always_ff @(posedge clk_i) begin
    s4_next_q <= s4_next;
    s4_diff_q <= {s4_next[31], s4_next} - {s3_pos_q[31], s3_pos_q};
  end

  // stage 5: |next - p| * inv_dt
  logic        [32:0] diff_mag;
  logic               s5_neg_q;
  logic        [64:0] s5_prod_q;
  logic signed [31:0] s5_next_q;

  assign diff_mag = s4_diff_q[32] ? 33'(~$unsigned(s4_diff_q) + 33'd1)
                                  : $unsigned(s4_diff_q);

  always_ff @(posedge clk_i) begin
    s5_neg_q  <= s4_diff_q[32];
    s5_prod_q <= 65'(diff_mag) * 65'(inv_dt_i);
    s5_next_q <= s4_next_q;
  end

  // final round and clamp; the top level registers the result
  logic        [65:0] s6_rnd;
  logic signed [66:0] s6_mag, s6_vel_raw;

  always_comb begin
    s6_rnd     = ({1'b0, s5_prod_q} + HALF_S6) >> FRAC_BITS;
    s6_mag     = {1'b0, s6_rnd};
    s6_vel_raw = s5_neg_q ? -s6_mag : s6_mag;
  end

  assign new_vel_o = sat32({{5{s6_vel_raw[66]}}, s6_vel_raw});
  assign new_pos_o = s5_next_q;

endmodule

/* src/verlet_body_step_unit.sv */
// Channel   Ports                                  Moves
// command   start_i, busy_o, cmd_i (vbs_in_t)       one body word in
// result    done_o, res_o (vbs_out_t)              one stepped body word out
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i       register write, no wait
//
// Six-stage pipeline: a word taken at one edge comes out on done_o/res_o once
// it has passed every stage; one word per cycle. Depth is set by the three multipliers
// (v*coef, a*dt^2, dx*inv_dt), each with its rounding stage.
// busy_o is registered: high in reset, cleared by the clock after reset ends, low from then on.
// Results are strobed for one cycle; the pipeline never stalls.
module verlet_body_step_unit import vbs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  vbs_in_t               cmd_i,
  output logic                  done_o,
  output vbs_out_t              res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AXIS_STAGES = 5;
  localparam int unsigned LATENCY = AXIS_STAGES + 1;

  logic signed [31:0] grav_x_q, grav_y_q;
  logic        [31:0] dt_sq_q, inv_dt_q;
  logic               busy_q;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q <= '0;
      grav_y_q <= '0;
      dt_sq_q  <= '0;
      inv_dt_q <= INV_DT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAVITY_X:  grav_x_q <= cfg_wdata_i;
        CFG_GRAVITY_Y:  grav_y_q <= cfg_wdata_i;
        CFG_DT_SQUARED: dt_sq_q  <= cfg_wdata_i;
        CFG_INV_DT:     inv_dt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  logic [24:0] coef;
  assign coef = {1'b0, cmd_i.damping} + {1'b0, cmd_i.friction};

  logic signed [31:0] ax_pos_x, ax_vel_x, ax_pos_y, ax_vel_y;

  vbs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk_i     (clk_i),
    .grav_i    (grav_x_q),
    .pos_i     (cmd_i.pos_x),
    .prev_i    (cmd_i.prev_x),
    .vel_i     (cmd_i.vel_x),
    .coef_i    (coef),
    .dt_sq_i   (dt_sq_q),
    .inv_dt_i  (inv_dt_q),
    .new_pos_o (ax_pos_x),
    .new_vel_o (ax_vel_x)
  );

  vbs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk_i     (clk_i),
    .grav_i    (grav_y_q),
    .pos_i     (cmd_i.pos_y),
    .prev_i    (cmd_i.prev_y),
    .vel_i     (cmd_i.vel_y),
    .coef_i    (coef),
    .dt_sq_i   (dt_sq_q),
    .inv_dt_i  (inv_dt_q),
    .new_pos_o (ax_pos_y),
    .new_vel_o (ax_vel_y)
  );

  // valid bits and the original word travel alongside the axis pipelines
  logic    [AXIS_STAGES-1:0] vld_q;
  vbs_in_t                   pipe_q [AXIS_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[AXIS_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= cmd_i;
    for (int i = 1; i < AXIS_STAGES; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  vbs_in_t  tail;
  vbs_out_t res_d, res_q;
  logic     done_q;

  assign tail = pipe_q[AXIS_STAGES-1];

  always_comb begin
    if (tail.is_static) begin
      res_d.new_pos_x  = tail.pos_x;
      res_d.new_pos_y  = tail.pos_y;
      res_d.new_prev_x = tail.prev_x;
      res_d.new_prev_y = tail.prev_y;
      res_d.new_vel_x  = tail.vel_x;
      res_d.new_vel_y  = tail.vel_y;
    end else begin
      res_d.new_pos_x  = ax_pos_x;
      res_d.new_pos_y  = ax_pos_y;
      res_d.new_prev_x = tail.pos_x;
      res_d.new_prev_y = tail.pos_y;
      res_d.new_vel_x  = ax_vel_x;
      res_d.new_vel_y  = ax_vel_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[AXIS_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a word taken");

  a_word_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept, LATENCY) && $past(rst_ni, LATENCY) |-> done_o)
    else $error("word taken but no result strobe");

  a_static_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(cmd_i.is_static, LATENCY)
      |-> res_o.new_pos_x == $past(cmd_i.pos_x, LATENCY)
       && res_o.new_vel_y == $past(cmd_i.vel_y, LATENCY))
    else $error("static body altered");

  a_prev_is_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(cmd_i.is_static, LATENCY)
      |-> res_o.new_prev_y == $past(cmd_i.pos_y, LATENCY))
    else $error("new previous position is not the old position");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import vbs_pkg::*;

  localparam int unsigned FRAC        = 16;
  localparam int unsigned PIPE_LAT    = 6;
  localparam int unsigned MAX_GAP     = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 125;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  vbs_in_t               cmd;
  logic                  done;
  vbs_out_t              res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Local copy of the register file, kept in step with every write.
  logic signed [31:0] grav_x_q = '0;
  logic signed [31:0] grav_y_q = '0;
  logic        [31:0] dt_sq_q  = '0;
  logic        [31:0] inv_dt_q = INV_DT_RESET;

  vbs_out_t    stepped_q[$];
  int unsigned err_cnt   = 0;
  int unsigned n_sent    = 0;
  int unsigned n_static  = 0;
  int unsigned n_checked = 0;
  int unsigned n_cfg     = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle   = 1'b0;

  verlet_body_step_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact product of |a| and b, shifted right, rounded half away from zero.
  function automatic logic signed [71:0] rnd_mul(input logic signed [71:0] a,
                                                 input logic [31:0] b,
                                                 input int unsigned sh);
    logic        [71:0]  mag;
    logic        [127:0] prod;
    logic signed [71:0]  r;
    mag  = a[71] ? -a : a;
    prod = 128'(mag) * 128'(b);
    prod = (prod + (128'd1 << (sh - 1))) >> sh;
    r    = prod[71:0];
    return a[71] ? -r : r;
  endfunction

  function automatic logic signed [31:0] clamp_s32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh0_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -72'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic void advance_axis(input logic signed [31:0] g, p, q, v,
                                       input logic [24:0] coef,
                                       output logic signed [31:0] np, nv);
    logic signed [71:0] pw;
    logic signed [71:0] nxt;
    logic signed [31:0] acc;
    pw  = 72'(p);
    acc = clamp_s32(72'(g) - rnd_mul(72'(v), 32'(coef), FRAC));
    nxt = (pw <<< 1) - 72'(q) + rnd_mul(72'(acc), dt_sq_q, 32);
    np  = clamp_s32(nxt);
    nxt = 72'(np);
    nv  = clamp_s32(rnd_mul(nxt - pw, inv_dt_q, FRAC));
  endfunction

  function automatic vbs_out_t step_body(input vbs_in_t b);
    vbs_out_t           o;
    logic        [24:0] coef;
    logic signed [31:0] npx, nvx, npy, nvy;
    coef = 25'(b.damping) + 25'(b.friction);
    if (b.is_static) begin
      o.new_pos_x  = b.pos_x;
      o.new_pos_y  = b.pos_y;
      o.new_prev_x = b.prev_x;
      o.new_prev_y = b.prev_y;
      o.new_vel_x  = b.vel_x;
      o.new_vel_y  = b.vel_y;
    end else begin
      advance_axis(grav_x_q, b.pos_x, b.prev_x, b.vel_x, coef, npx, nvx);
      advance_axis(grav_y_q, b.pos_y, b.prev_y, b.vel_y, coef, npy, nvy);
      o.new_pos_x  = npx;
      o.new_pos_y  = npy;
      o.new_prev_x = b.pos_x;
      o.new_prev_y = b.pos_y;
      o.new_vel_x  = nvx;
      o.new_vel_y  = nvy;
    end
    return o;
  endfunction

  function automatic vbs_in_t mk_body(input logic st,
                                      input logic [31:0] px, py, qx, qy, vx, vy,
                                      input logic [23:0] damp, fric);
    vbs_in_t b;
    b.is_static = st;
    b.pos_x     = px;
    b.pos_y     = py;
    b.prev_x    = qx;
    b.prev_y    = qy;
    b.vel_x     = vx;
    b.vel_y     = vy;
    b.damping   = damp;
    b.friction  = fric;
    return b;
  endfunction

  // Signed random value of the given width, sign-extended.
  function automatic logic signed [31:0] small_s(input int unsigned bits);
    logic signed [31:0] r;
    r = $urandom;
    return r >>> (32 - bits);
  endfunction

  function automatic logic [31:0] corner_val();
    logic [31:0] r;
    case ($urandom_range(0, 5))
      0: r = 32'h7fff_ffff;
      1: r = 32'h8000_0000;
      2: r = 32'h0;
      3: r = 32'hffff_ffff;
      4: r = 32'h1;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  function automatic vbs_in_t rand_body();
    vbs_in_t     b;
    int unsigned kind;
    kind        = $urandom_range(0, 9);
    b.is_static = ($urandom_range(0, 9) == 0);
    b.pos_x     = $urandom;
    b.pos_y     = $urandom;
    b.prev_x    = $urandom;
    b.prev_y    = $urandom;
    b.vel_x     = $urandom;
    b.vel_y     = $urandom;
    b.damping   = 24'($urandom_range(0, 24'hff_ffff));
    b.friction  = 24'($urandom_range(0, 24'hff_ffff));
    if (kind < 5) begin
      // plausible body: prev close to pos, modest speed and drag
      b.pos_x    = small_s(28);
      b.pos_y    = small_s(28);
      b.prev_x   = b.pos_x + small_s(18);
      b.prev_y   = b.pos_y + small_s(18);
      b.vel_x    = small_s(22);
      b.vel_y    = small_s(22);
      b.damping  = 24'($urandom_range(0, 32'h0002_0000));
      b.friction = 24'($urandom_range(0, 32'h0001_0000));
    end else if (kind == 8) begin
      b.pos_x    = corner_val();
      b.pos_y    = corner_val();
      b.prev_x   = corner_val();
      b.prev_y   = corner_val();
      b.vel_x    = corner_val();
      b.vel_y    = corner_val();
      b.damping  = $urandom_range(0, 1) ? 24'hff_ffff : 24'h0;
      b.friction = $urandom_range(0, 1) ? 24'hff_ffff : 24'h0;
    end else if (kind == 9) begin
      b.damping  = '0;
      b.friction = '0;
    end
    return b;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Hold the word on cmd until the block takes it, then log its prediction.
  task automatic send_body(input vbs_in_t b);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    stepped_q.push_back(step_body(b));
    n_sent++;
    if (b.is_static) n_static++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (stepped_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] gx, gy, dsq, idt);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GRAVITY_X;
    cfg_wdata <= gx;
    @(posedge clk);
    cfg_idx   <= CFG_GRAVITY_Y;
    cfg_wdata <= gy;
    @(posedge clk);
    cfg_idx   <= CFG_DT_SQUARED;
    cfg_wdata <= dsq;
    @(posedge clk);
    cfg_idx   <= CFG_INV_DT;
    cfg_wdata <= idt;
    @(posedge clk);
    cfg_we   <= 1'b0;
    grav_x_q = gx;
    grav_y_q = gy;
    dt_sq_q  = dsq;
    inv_dt_q = idt;
    n_cfg++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : chk_results
    vbs_out_t want;
    if (done === 1'b1) begin
      if (stepped_q.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        want = stepped_q.pop_front();
        check_field("new_pos_x",  want.new_pos_x,  res.new_pos_x);
        check_field("new_pos_y",  want.new_pos_y,  res.new_pos_y);
        check_field("new_prev_x", want.new_prev_x, res.new_prev_x);
        check_field("new_prev_y", want.new_prev_y, res.new_prev_y);
        check_field("new_vel_x",  want.new_vel_x,  res.new_vel_x);
        check_field("new_vel_y",  want.new_vel_y,  res.new_vel_y);
        n_checked++;
      end
    end
  end

  // Registers at their reset values: plain 2p - prev, velocity = step.
  task automatic test_reset_values();
    send_body(mk_body(1'b0, 32'h0003_0000, 32'hfffb_0000, 32'h0001_0000, 32'hfffe_0000,
                      $urandom, $urandom, 24'h01_0000, 24'h00_8000));
    send_body(mk_body(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff, 24'hff_ffff));
    send_body(mk_body(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0, 24'h0));
  endtask

  task automatic test_static();
    apply_config($urandom, $urandom, $urandom, $urandom);
    send_body(mk_body(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff, 24'hff_ffff));
    send_body(mk_body(1'b1, 32'h0, 32'hffff_ffff, 32'h1, 32'h0, 32'h0, 32'h1, 24'h0, 24'h0));
    send_body(mk_body(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      24'h12_3456, 24'hab_cdef));
  endtask

  // Saturation of acceleration, position and velocity at both ends.
  task automatic test_extremes();
    apply_config(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
    send_body(mk_body(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff, 24'hff_ffff));
    send_body(mk_body(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0, 24'h0));
    send_body(mk_body(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 24'hff_ffff, 24'hff_ffff));
    send_body(mk_body(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 24'hff_ffff, 24'h0));
    apply_config(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    send_body(mk_body(1'b0, 32'h1234_5678, 32'hedcb_a988, 32'h0, 32'h0,
                      32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff, 24'hff_ffff));
    send_body(mk_body(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h0, 32'h0, 24'h0, 24'h0));
  endtask

  // Exact halves at each rounding step, both signs.
  task automatic test_rounding();
    apply_config(32'h0, 32'h0, 32'h8000_0000, INV_DT_RESET);
    send_body(mk_body(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'hffff_ffff,
                      24'h00_8000, 24'h0));
    send_body(mk_body(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3, 32'hffff_fffd,
                      24'h0, 24'h00_8000));
    apply_config(32'h0000_0001, 32'hffff_ffff, 32'h8000_0000, 32'h0000_8000);
    send_body(mk_body(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0, 24'h0));
    send_body(mk_body(1'b0, 32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0,
                      24'h0, 24'h0));
  endtask

  task automatic test_random();
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 5)
        0: apply_config(small_s(17), -$urandom_range(0, 32'h0014_0000),
                        $urandom_range(1000, 2000000), $urandom_range(30, 240) << FRAC);
        1: apply_config($urandom, $urandom, $urandom, $urandom);
        2: apply_config(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        3: apply_config(32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h0);
        default: apply_config($urandom, $urandom, $urandom_range(32'hf000_0000, 32'hffff_ffff),
                              $urandom);
      endcase
      no_idle = (ph % 4 == 3);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) send_body(rand_body());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    cmd       <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_GRAVITY_X;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_static();
    test_extremes();
    test_rounding();
    test_random();
    drain();
    $display("Stepped %0d bodies (%0d static), %0d results checked, %0d register settings",
             n_sent, n_static, n_checked, n_cfg);
    $display("Settings spanned reset values, full-scale extremes and random configs");
    if (err_cnt == 0 && stepped_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles", cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/vbs_pkg.sv
src/vbs_axis.sv
src/verlet_body_step_unit.sv
dv/tb.sv
